// ----- rtl/dcdroop_pkg.sv -----
// Shared constants and register map for the DC droop voltage setpoint block.
`default_nettype none

package dcdroop_pkg;

  localparam int unsigned CurW   = 16;
  localparam int unsigned VoltW  = 16;
  localparam int unsigned PowW   = 24;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned DivSteps = 16;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [2:0] RegBaseVoltage = 3'd0;
  localparam logic [2:0] RegSlope       = 3'd1;
  localparam logic [2:0] RegPowerLimit  = 3'd2;
  localparam logic [2:0] RegNoLoadVolt  = 3'd3;
  localparam logic [2:0] RegMinCurrent  = 3'd4;

  localparam logic [15:0] BaseVoltageRst = 16'd3840;
  localparam logic [15:0] SlopeRst       = 16'hEE14;  // -4588
  localparam logic [23:0] PowerLimitRst  = 24'd15360;
  localparam logic [15:0] NoLoadVoltRst  = 16'd3840;
  localparam logic [15:0] MinCurrentRst  = 16'd26;

  localparam logic [15:0] VoltMax = 16'hFFFF;

endpackage

`default_nettype wire

// ----- rtl/dc_droop_voltage_setpoint_top.sv -----
// Top level of the DC droop voltage setpoint block: registers, sequencer and shared datapath.
`default_nettype none

// One current sample in, one voltage/power beat out. A sample below min_current
// goes from accept straight to the state that loads the output register. Any
// other sample runs through one shared 17x17 multiplier and one shared
// restoring divider. When both the droop and the power limit divisions run,
// the steps are, in order: the slope product, the denominator check, the droop
// division, the power product, the limit check, the limit division and the load
// of the output register; without the limit division the limit check goes
// straight to the load. The next sample is accepted only once the block is back
// in idle after the load, so a new sample is never taken before the last one is
// through. The input is stalled while a sample is in work; a finished beat waits
// in the output register so the next sample can be accepted, and a sample that
// finishes while that beat is still stalled waits until the receiver takes it.
// The configuration registers must only be written while no sample is in work.
module dc_droop_voltage_setpoint_top (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcdroop_pkg::AddrW-1:0] paddr,
  input  logic [dcdroop_pkg::DataW-1:0] pwdata,
  output logic [dcdroop_pkg::DataW-1:0] prdata,
  output logic                          pready,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dcdroop_pkg::CurW-1:0]  current,
  // Output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dcdroop_pkg::VoltW-1:0] voltage,
  output logic [dcdroop_pkg::PowW-1:0]  power,
  output logic                          power_limited,
  output logic                          below_min
);
  import dcdroop_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_DEN,
    S_DEN,
    S_DIV_V,
    S_MUL_P,
    S_PWR,
    S_DIV_L,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [15:0] base_voltage;
  logic [15:0] slope;
  logic [23:0] power_limit;
  logic [15:0] no_load_voltage;
  logic [15:0] min_current;

  logic [23:0] last_power;

  // Working registers
  logic [CurW-1:0]  cur_q;
  logic [33:0]      prod;
  logic [31:0]      dvs;
  logic [31:0]      rem;
  logic [15:0]      shl;
  logic [3:0]       cnt;
  logic [VoltW-1:0] volt_r;
  logic [PowW-1:0]  pwr_r;
  logic             lim_r;
  logic             bm_r;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_voltage    <= BaseVoltageRst;
      slope           <= SlopeRst;
      power_limit     <= PowerLimitRst;
      no_load_voltage <= NoLoadVoltRst;
      min_current     <= MinCurrentRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegBaseVoltage: base_voltage    <= pwdata[15:0];
        RegSlope:       slope           <= pwdata[15:0];
        RegPowerLimit:  power_limit     <= pwdata[23:0];
        RegNoLoadVolt:  no_load_voltage <= pwdata[15:0];
        RegMinCurrent:  min_current     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegBaseVoltage: prdata = {16'b0, base_voltage};
      RegSlope:       prdata = {16'b0, slope};
      RegPowerLimit:  prdata = {8'b0, power_limit};
      RegNoLoadVolt:  prdata = {16'b0, no_load_voltage};
      RegMinCurrent:  prdata = {16'b0, min_current};
      default:        prdata = '0;
    endcase
  end

  // Shared multiplier: slope times current, then voltage times current.
  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] mul_p;

  always_comb begin
    if (state == S_MUL_DEN) begin
      mul_a = $signed({1'b0, cur_q});
      mul_b = $signed({slope[15], slope});
    end else begin
      mul_a = $signed({1'b0, volt_r});
      mul_b = $signed({1'b0, cur_q});
    end
  end
  assign mul_p = mul_a * mul_b;

  // Denominator of the droop curve in signed Q11.24.
  logic signed [34:0] den;
  logic               den_pos;
  logic               droop_ovf;
  assign den       = $signed(35'sd16777216) - $signed({prod[33], prod});
  assign den_pos   = !den[34] && (den != '0);
  assign droop_ovf = ({8'b0, base_voltage, 8'b0} >= den[31:0]);

  // Shared restoring divider step: one quotient bit per cycle.
  logic [32:0] div_r2;
  logic        div_ge;
  logic [32:0] div_diff;
  logic [31:0] rem_next;
  assign div_r2   = {rem, shl[15]};
  assign div_ge   = div_r2 >= {1'b0, dvs};
  assign div_diff = div_r2 - {1'b0, dvs};
  assign rem_next = div_ge ? div_diff[31:0] : div_r2[31:0];
  logic div_last;
  assign div_last = (cnt == 4'(DivSteps - 1));

  logic [23:0] pwr_raw;
  assign pwr_raw = prod[31:8];

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      last_power <= '0;
      cnt        <= '0;
    end else begin
      // A beat that leaves is cleared here unless S_DONE loads the next one.
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_q <= current;
            if (current < min_current) begin
              volt_r <= no_load_voltage;
              pwr_r  <= last_power;
              lim_r  <= 1'b0;
              bm_r   <= 1'b1;
              state  <= S_DONE;
            end else begin
              bm_r  <= 1'b0;
              lim_r <= 1'b0;
              state <= S_MUL_DEN;
            end
          end
        end
        S_MUL_DEN: begin
          prod  <= mul_p;
          state <= S_DEN;
        end
        S_DEN: begin
          // A non-positive denominator counts as a division by zero.
          if (!den_pos || droop_ovf) begin
            volt_r <= VoltMax;
            state  <= S_MUL_P;
          end else begin
            dvs   <= den[31:0];
            rem   <= {8'b0, base_voltage, 8'b0};
            shl   <= '0;
            cnt   <= '0;
            state <= S_DIV_V;
          end
        end
        S_DIV_V, S_DIV_L: begin
          rem    <= rem_next;
          shl    <= {shl[14:0], 1'b0};
          volt_r <= {volt_r[14:0], div_ge};
          cnt    <= cnt + 4'd1;
          if (div_last) begin
            state <= (state == S_DIV_V) ? S_MUL_P : S_DONE;
          end
        end
        S_MUL_P: begin
          prod  <= mul_p;
          state <= S_PWR;
        end
        S_PWR: begin
          if (pwr_raw >= power_limit) begin
            pwr_r      <= power_limit;
            last_power <= power_limit;
            lim_r      <= 1'b1;
            // Quotient would not fit in 16 bits; also covers zero current.
            if (power_limit[23:8] >= cur_q) begin
              volt_r <= VoltMax;
              state  <= S_DONE;
            end else begin
              dvs   <= {16'b0, cur_q};
              rem   <= {16'b0, power_limit[23:8]};
              shl   <= {power_limit[7:0], 8'b0};
              cnt   <= '0;
              state <= S_DIV_L;
            end
          end else begin
            pwr_r      <= pwr_raw;
            last_power <= pwr_raw;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            voltage       <= volt_r;
            power         <= pwr_r;
            power_limited <= lim_r;
            below_min     <= bm_r;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted again before the sample finished");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(below_min && power_limited))
    else $error("below-minimum beat flagged as power limited");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIV_V) && div_last) |=> (state == S_MUL_P))
    else $error("droop division did not hand over to the power step");

endmodule

`default_nettype wire

// ----- tb/dc_droop_voltage_setpoint_top_test.sv -----
// Self-checking testbench for the DC droop voltage setpoint block.
module dc_droop_voltage_setpoint_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dcdroop_pkg::*;

  typedef longint s64_t;
  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [VoltW-1:0] voltage;
    logic [PowW-1:0]  power;
    logic             limited;
    logic             below;
  } setpoint_t;

  typedef enum logic [1:0] {RowSample, RowTyped, RowWrite} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [31:0] data;
    setpoint_t   want;
  } dir_row_t;

  localparam logic [2:0] RegUnused = 3'd5;
  localparam int DirRows      = 37;
  localparam int DrainCycles  = 48;
  localparam int QuietLimit   = 4000;
  localparam int HoldCycles   = 300;
  localparam int RandPhases   = 8;
  localparam int PhaseItems   = 50;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic [CurW-1:0]   current;
  logic              out_valid;
  logic              out_stall;
  logic [VoltW-1:0]  voltage;
  logic [PowW-1:0]   power;
  logic              power_limited;
  logic              below_min;

  dc_droop_voltage_setpoint_top u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .current(current),
    .out_valid(out_valid), .out_stall(out_stall), .voltage(voltage),
    .power(power), .power_limited(power_limited), .below_min(below_min)
  );

  // Local copy of the block's registers and held power.
  logic [15:0] cfg_base;
  logic [15:0] cfg_slope;
  logic [23:0] cfg_power_limit;
  logic [15:0] cfg_no_load;
  logic [15:0] cfg_min_current;
  logic [23:0] held_power;

  setpoint_t pending_setpoints[$];
  setpoint_t beat_want;
  int        mismatch_count;
  int        quiet_cycles;
  int        send_idle_pct;
  int        recv_stall_pct;
  bit        hold_request;
  int        hold_left;
  dir_row_t  directed_rows [DirRows];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input u64_t got, input u64_t want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [15:0] sat_volt(input u64_t q);
    return (q > u64_t'(VoltMax)) ? VoltMax : q[15:0];
  endfunction

  // Computes one setpoint beat and, for a sample at or above the threshold, updates the held power.
  function automatic setpoint_t droop_setpoint(input logic [15:0] cur);
    setpoint_t r;
    s64_t      den;
    u64_t      prod;
    r.limited = 1'b0;
    r.below = 1'b0;
    if (cur < cfg_min_current) begin
      r.voltage = cfg_no_load;
      r.power = held_power;
      r.below = 1'b1;
      return r;
    end
    den = (s64_t'(1) <<< 24) - s64_t'(cur) * s64_t'($signed(cfg_slope));
    if (den <= 0) begin
      r.voltage = VoltMax;
    end else begin
      r.voltage = sat_volt((u64_t'(cfg_base) << 24) / u64_t'(den));
    end
    prod = (u64_t'(r.voltage) * u64_t'(cur)) >> 8;
    r.power = prod[23:0];
    if (r.power >= cfg_power_limit) begin
      r.power = cfg_power_limit;
      r.limited = 1'b1;
      if (cur == 16'd0) begin
        r.voltage = VoltMax;
      end else begin
        r.voltage = sat_volt((u64_t'(cfg_power_limit) << 8) / u64_t'(cur));
      end
    end
    held_power = r.power;
    return r;
  endfunction

  function automatic dir_row_t row_write(input logic [2:0] idx, input logic [31:0] value);
    return '{kind: RowWrite, idx: idx, data: value, want: '0};
  endfunction

  function automatic dir_row_t row_sample(input logic [15:0] cur);
    return '{kind: RowSample, idx: 3'd0, data: {16'd0, cur}, want: '0};
  endfunction

  function automatic dir_row_t row_typed(input logic [15:0] cur, input logic [15:0] v,
                                         input logic [23:0] p, input logic lim,
                                         input logic blw);
    return '{kind: RowTyped, idx: 3'd0, data: {16'd0, cur}, want: '{v, p, lim, blw}};
  endfunction

  // Entered and left just after a falling edge.
  task automatic send_sample(input logic [15:0] cur, input bit use_typed,
                             input setpoint_t typed_want);
    setpoint_t model;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    current <= cur;
    do @(posedge clk); while (in_stall);
    model = droop_setpoint(cur);
    pending_setpoints.push_back(use_typed ? typed_want : model);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_setpoints.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Write one register, then read it back where it exists.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    case (idx)
      RegBaseVoltage: cfg_base = value[15:0];
      RegSlope:       cfg_slope = value[15:0];
      RegPowerLimit:  cfg_power_limit = value[23:0];
      RegNoLoadVolt:  cfg_no_load = value[15:0];
      RegMinCurrent:  cfg_min_current = value[15:0];
      default: ;
    endcase
    if (idx > RegMinCurrent) begin
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
    end else begin
      mask = (idx == RegPowerLimit) ? 32'h00FF_FFFF : 32'h0000_FFFF;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if ((prdata & mask) !== (value & mask)) begin
        flag_mismatch($sformatf("readback of register %0d", idx), prdata & mask, value & mask);
      end
      @(negedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task automatic randomize_config();
    wait_idle();
    write_reg(RegBaseVoltage, ($urandom_range(1) == 0) ? $urandom_range(65535)
                                                       : $urandom_range(8000, 2000));
    write_reg(RegSlope, {16'd0, 16'(-$urandom_range(32768))});
    write_reg(RegPowerLimit, ($urandom_range(3) == 0) ? $urandom_range(24'hFFFFFF)
                                                      : $urandom_range(40000));
    write_reg(RegNoLoadVolt, $urandom_range(65535));
    case ($urandom_range(3))
      0: write_reg(RegMinCurrent, 32'd0);
      1: write_reg(RegMinCurrent, $urandom_range(65535));
      default: write_reg(RegMinCurrent, $urandom_range(300, 1));
    endcase
  endtask

  // Currents cluster around the threshold and the usual operating range.
  function automatic logic [15:0] pick_current();
    int lo;
    int hi;
    lo = (cfg_min_current == 0) ? 0 : cfg_min_current - 1;
    hi = (cfg_min_current == 16'hFFFF) ? 65535 : cfg_min_current + 1;
    case ($urandom_range(9))
      0, 1, 2, 3: return 16'($urandom_range(65535));
      4, 5, 6:    return 16'($urandom_range(4096));
      7:          return 16'($urandom_range(hi, lo));
      8:          return ($urandom_range(1) == 0) ? 16'd0 : 16'hFFFF;
      default:    return 16'($urandom_range((2 * int'(cfg_min_current) > 65535) ? 65535
                                            : 2 * int'(cfg_min_current)));
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_setpoints.size() == 0) begin
        flag_mismatch("beat with nothing pending, voltage", voltage, 0);
      end else begin
        beat_want = pending_setpoints.pop_front();
        if (voltage !== beat_want.voltage)
          flag_mismatch("voltage", voltage, beat_want.voltage);
        if (power !== beat_want.power)
          flag_mismatch("power", power, beat_want.power);
        if (power_limited !== beat_want.limited)
          flag_mismatch("power_limited", power_limited, beat_want.limited);
        if (below_min !== beat_want.below)
          flag_mismatch("below_min", below_min, beat_want.below);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("dc_droop_voltage_setpoint_top_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    current = '0;
    mismatch_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b0;
    cfg_base = BaseVoltageRst;
    cfg_slope = SlopeRst;
    cfg_power_limit = PowerLimitRst;
    cfg_no_load = NoLoadVoltRst;
    cfg_min_current = MinCurrentRst;
    held_power = '0;

    directed_rows = '{
      // Reset settings: threshold, full scale, and the held power.
      row_typed(16'd0, 16'd3840, 24'd0, 1'b0, 1'b1),
      row_typed(16'd25, 16'd3840, 24'd0, 1'b0, 1'b1),
      row_sample(16'd26),
      row_typed(16'hFFFF, 16'd60, 24'd15360, 1'b1, 1'b0),
      row_typed(16'd0, 16'd3840, 24'd15360, 1'b0, 1'b1),
      row_sample(16'd256),
      // Zero limit and zero threshold: zero current lands on the limit path.
      row_write(RegPowerLimit, 32'd0),
      row_write(RegMinCurrent, 32'd0),
      row_typed(16'd0, 16'hFFFF, 24'd0, 1'b1, 1'b0),
      row_typed(16'd1, 16'd0, 24'd0, 1'b1, 1'b0),
      // Top of the power limit and base voltage ranges, zero no-load voltage, steepest slope.
      row_write(RegPowerLimit, 32'h00FF_FFFF),
      row_write(RegBaseVoltage, 32'h0000_FFFF),
      row_write(RegSlope, 32'h0000_8000),
      row_write(RegNoLoadVolt, 32'd0),
      row_write(RegUnused, 32'hFFFF_FFFF),
      row_typed(16'd0, 16'hFFFF, 24'd0, 1'b0, 1'b0),
      row_sample(16'hFFFF),
      row_sample(16'd1),
      // Flat slope, zero base, highest threshold.
      row_write(RegSlope, 32'd0),
      row_write(RegBaseVoltage, 32'd0),
      row_write(RegNoLoadVolt, 32'h0000_FFFF),
      row_write(RegMinCurrent, 32'h0000_FFFF),
      row_sample(16'hFFFE),
      row_typed(16'hFFFF, 16'd0, 24'd0, 1'b0, 1'b0),
      row_typed(16'hFFFE, 16'hFFFF, 24'd0, 1'b0, 1'b1),
      // A positive slope drives the denominator down to just above zero and below it.
      row_write(RegSlope, 32'h0000_7FFF),
      row_write(RegBaseVoltage, 32'd3840),
      row_write(RegMinCurrent, 32'd0),
      row_sample(16'hFFFF),
      row_sample(16'd512),
      row_sample(16'd513),
      // Power exactly at the limit, then one below it.
      row_write(RegSlope, 32'd0),
      row_write(RegPowerLimit, 32'd3840),
      row_typed(16'd256, 16'd3840, 24'd3840, 1'b1, 1'b0),
      row_write(RegPowerLimit, 32'd3841),
      row_typed(16'd256, 16'd3840, 24'd3840, 1'b0, 1'b0),
      row_sample(16'd255)
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[n]) begin
      if (directed_rows[n].kind == RowWrite) begin
        wait_idle();
        write_reg(directed_rows[n].idx, directed_rows[n].data);
      end else begin
        send_sample(directed_rows[n].data[15:0], directed_rows[n].kind == RowTyped,
                    directed_rows[n].want);
      end
    end

    for (int ph = 0; ph < RandPhases; ph++) begin
      randomize_config();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      // Back up the output while the sender keeps offering samples.
      if (ph == 0) hold_request = 1'b1;
      for (int k = 0; k < PhaseItems; k++) begin
        send_sample(pick_current(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_setpoints.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("dc_droop_voltage_setpoint_top_test: done, clean");
    end else begin
      $display("dc_droop_voltage_setpoint_top_test: done, errors");
    end
    $finish;
  end

endmodule
